### hw/rtl/ssnfb_pkg.sv
// Package for the seven-segment number frame builder.
// Widths, command bytes, register indexes, divider structs and the segment table.
// No dependencies.
package ssnfb_pkg;

    localparam int NUM_DIGITS_DEF = 4;

    localparam int NUM_W   = 16;
    localparam int BASE_W  = 5;
    localparam int DOT_W   = 8;
    localparam int CNT_W   = 3;
    localparam int POS_W   = 2;
    localparam int SEG_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int BRT_W   = 3;
    localparam int REM_W   = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd1;

    localparam logic OP_SHOW  = 1'b0;
    localparam logic OP_BLANK = 1'b1;

    localparam logic [BYTE_W-1:0] CMD_DATA_MODE = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_ADDRESS   = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_CONTROL   = 8'h80;
    localparam logic [BYTE_W-1:0] ADDR_MASK     = 8'h03;
    localparam logic [BYTE_W-1:0] CTRL_MASK     = 8'h0F;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [BASE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quotient;
        logic [REM_W-1:0]  remainder;
    } div_rsp_t;

    // segments g..a, point bit kept apart
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] s;
        case (digit)
            4'h0:    s = 7'b0111111;
            4'h1:    s = 7'h06;
            4'h2:    s = 7'h5B;
            4'h3:    s = 7'h4F;
            4'h4:    s = 7'h66;
            4'h5:    s = 7'h6D;
            4'h6:    s = 7'h7D;
            4'h7:    s = 7'h07;
            4'h8:    s = 7'h7F;
            4'h9:    s = 7'h6F;
            4'hA:    s = 7'h77;
            4'hB:    s = 7'h7C;
            4'hC:    s = 7'h39;
            4'hD:    s = 7'h5E;
            4'hE:    s = 7'h79;
            default: s = 7'b1110001;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/ssnfb_req_if.sv
// Request channel: valid/ready plus the display request fields.
// Depends on ssnfb_pkg.
interface ssnfb_req_if
    import ssnfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [NUM_W-1:0]  number;
    logic [BASE_W-1:0] base;
    logic [DOT_W-1:0]  dot_mask;
    logic              show_leading_zeros;
    logic [CNT_W-1:0]  digit_count;
    logic [POS_W-1:0]  start_position;

    modport source (output valid, opcode, number, base, dot_mask, show_leading_zeros,
                    digit_count, start_position, input ready);
    modport sink   (input valid, opcode, number, base, dot_mask, show_leading_zeros,
                    digit_count, start_position, output ready);
endinterface

### hw/rtl/ssnfb_frame_if.sv
// Frame byte channel: valid/ready plus one bus byte and its framing flags.
// Depends on ssnfb_pkg.
interface ssnfb_frame_if
    import ssnfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] bus_byte;
    logic              frame_start;
    logic              frame_end;
    logic              last;

    modport source (output valid, bus_byte, frame_start, frame_end, last, input ready);
    modport sink   (input valid, bus_byte, frame_start, frame_end, last, output ready);
endinterface

### hw/rtl/ssnfb_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on ssnfb_pkg.
interface ssnfb_cfg_if
    import ssnfb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/seven_segment_number_frame_builder.sv
// Seven-segment number frame builder: takes one display request item at a time and
// emits its command and segment bytes as items on the frame channel. A number
// request costs digit_count passes through one shared 16-bit divider and then
// emits digit_count + 3 bytes at one per cycle while the sink takes them. A
// blank request skips the divider and emits NUM_DIGITS + 3 bytes. The request
// side is ready only between requests; it reopens as soon as the final byte
// sits in the output register.
// Configuration writes are always taken; index 0 is brightness, index 1 display on.
// Depends on ssnfb_pkg, ssnfb_*_if and ssnfb_div.
module seven_segment_number_frame_builder
    import ssnfb_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    ssnfb_req_if.sink        req,
    ssnfb_frame_if.source    frame,
    ssnfb_cfg_if.sink        cfg
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // byte phases within one request
    localparam logic [CNT_W-1:0] PH_DATA = 3'd0;
    localparam logic [CNT_W-1:0] PH_ADDR = 3'd1;
    localparam logic [CNT_W-1:0] PH_TAIL = 3'd2;   // control byte sits at count + 2

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(NUM_DIGITS);

    logic [1:0]        state_reg, state_next;
    logic              start_reg, start_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [DOT_W-1:0]  dots_reg, dots_next;
    logic              lz_reg, lz_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]  ph_reg, ph_next;
    logic [POS_W-1:0]  addr_reg, addr_next;
    logic [SEG_W-1:0]  cells_reg [NUM_DIGITS];
    logic [SEG_W-1:0]  cells_next [NUM_DIGITS];

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_fs_reg, out_fs_next;
    logic              out_fe_reg, out_fe_next;
    logic              out_last_reg, out_last_next;

    logic [BRT_W-1:0]  bright_reg;
    logic              enable_reg;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              out_load;
    logic [CNT_W-1:0]  ph_last;
    logic              blank_dig;
    logic [BASE_W-1:0] base_clamp;
    logic [CNT_W-1:0]  count_clamp;

    ssnfb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start    = start_reg;
    assign div_req.dividend = num_reg;
    assign div_req.divisor  = base_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || frame.ready);
    assign ph_last  = count_reg + PH_TAIL;

    // leading-zero blanking; the first digit is never blanked so a lone zero shows
    assign blank_dig = (div_rsp.remainder == '0) && (num_reg == '0) && !lz_reg && !first_reg;

    always_comb
    begin
        base_clamp = req.base;
        if (req.base < BASE_MIN)
            base_clamp = BASE_MIN;
        else if (req.base > BASE_MAX)
            base_clamp = BASE_MAX;
        count_clamp = req.digit_count;
        if (req.digit_count == '0)
            count_clamp = 3'd1;
        else if (req.digit_count > MAX_CNT)
            count_clamp = MAX_CNT;
    end

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        num_next   = num_reg;
        base_next  = base_reg;
        dots_next  = dots_reg;
        lz_next    = lz_reg;
        first_next = first_reg;
        count_next = count_reg;
        left_next  = left_reg;
        ph_next    = ph_reg;
        addr_next  = addr_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
            cells_next[i] = cells_reg[i];

        out_valid_next = (frame.ready) ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_fs_next    = out_fs_reg;
        out_fe_next    = out_fe_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ph_next = PH_DATA;
                    if (req.opcode == OP_BLANK)
                    begin
                        count_next = MAX_CNT;
                        addr_next  = '0;
                        dots_next  = '0;
                        for (int i = 0; i < NUM_DIGITS; i++)
                            cells_next[i] = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        num_next   = req.number;
                        base_next  = base_clamp;
                        dots_next  = req.dot_mask;
                        lz_next    = req.show_leading_zeros;
                        count_next = count_clamp;
                        left_next  = count_clamp;
                        addr_next  = req.start_position;
                        first_next = 1'b1;
                        start_next = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // digits arrive least significant first; push in at cell 0
                    for (int i = NUM_DIGITS - 1; i > 0; i--)
                        cells_next[i] = cells_reg[i-1];
                    cells_next[0] = blank_dig ? '0 : seg_of(div_rsp.remainder[3:0]);
                    num_next   = div_rsp.quotient;
                    first_next = 1'b0;
                    left_next  = left_reg - 1'b1;
                    if (left_reg == 3'd1)
                        state_next = S_OUT;
                    else
                        start_next = 1'b1;
                end
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    ph_next        = ph_reg + 1'b1;
                    out_last_next  = 1'b0;
                    if (ph_reg == PH_DATA)
                    begin
                        out_byte_next = CMD_DATA_MODE;
                        out_fs_next   = 1'b1;
                        out_fe_next   = 1'b1;
                    end
                    else if (ph_reg == PH_ADDR)
                    begin
                        out_byte_next = CMD_ADDRESS | (ADDR_MASK & {6'd0, addr_reg});
                        out_fs_next   = 1'b1;
                        out_fe_next   = 1'b0;
                    end
                    else if (ph_reg == ph_last)
                    begin
                        out_byte_next = CMD_CONTROL | (CTRL_MASK & {4'd0, enable_reg, bright_reg});
                        out_fs_next   = 1'b1;
                        out_fe_next   = 1'b1;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        // cell bytes go out from cell 0; the dot of cell i is mask bit 7-i
                        out_byte_next = {dots_reg[DOT_W-1], cells_reg[0]};
                        out_fs_next   = 1'b0;
                        out_fe_next   = (ph_reg == ph_last - 1'b1);
                        dots_next     = {dots_reg[DOT_W-2:0], 1'b0};
                        for (int i = 0; i < NUM_DIGITS - 1; i++)
                            cells_next[i] = cells_reg[i+1];
                        cells_next[NUM_DIGITS-1] = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bright_reg    <= 3'd7;
            enable_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.index == REG_BRIGHTNESS)
                bright_reg <= cfg.data[BRT_W-1:0];
            if (cfg.valid && cfg.index == REG_ENABLE)
                enable_reg <= cfg.data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        base_reg     <= base_next;
        dots_reg     <= dots_next;
        lz_reg       <= lz_next;
        first_reg    <= first_next;
        count_reg    <= count_next;
        left_reg     <= left_next;
        ph_reg       <= ph_next;
        addr_reg     <= addr_next;
        for (int i = 0; i < NUM_DIGITS; i++)
            cells_reg[i] <= cells_next[i];
        out_byte_reg <= out_byte_next;
        out_fs_reg   <= out_fs_next;
        out_fe_reg   <= out_fe_next;
        out_last_reg <= out_last_next;
    end

    assign frame.valid       = out_valid_reg;
    assign frame.bus_byte    = out_byte_reg;
    assign frame.frame_start = out_fs_reg;
    assign frame.frame_end   = out_fe_reg;
    assign frame.last        = out_last_reg;

endmodule

### hw/rtl/ssnfb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ssnfb_pkg (div_req_t, div_rsp_t).
module ssnfb_div
    import ssnfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [BASE_W-1:0] dvs_reg, dvs_next;
    logic [REM_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? REM_W'(trial - {1'b0, dvs_reg}) : trial[REM_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### hw/rtl/ssnfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
// Depends on the top level's channel interfaces only.
module ssnfb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_fs,
    input logic       out_fe,
    input logic       out_last
);

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in progress");

    // no new request while a non-final byte is still pending
    a_busy_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !req_ready)
        else $error("request side open mid-frame");

    // address command is the only byte opening a frame without closing it
    a_addr_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_fs && !out_fe |-> out_byte[7:6] == 2'b11)
        else $error("open-only frame byte is not an address command");

    // final byte is a single-byte display control frame
    a_last_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_fs && out_fe && out_byte[7:4] == 4'h8)
        else $error("final byte is not a display control command");

    // stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("stalled output byte changed");

endmodule

bind seven_segment_number_frame_builder ssnfb_checker u_ssnfb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.bus_byte),
    .out_fs    (frame.frame_start),
    .out_fe    (frame.frame_end),
    .out_last  (frame.last)
);

### sim/ssnfb_frame_checker.sv
// Checker for the seven-segment number frame builder: watches the request, frame and
// configuration channels, predicts the frame bytes of each request item and compares.
// Depends on ssnfb_pkg and the three ssnfb_*_if interfaces.
`timescale 1ns / 1ps

module ssnfb_frame_checker
    import ssnfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ssnfb_req_if      req,
    ssnfb_frame_if    frame,
    ssnfb_cfg_if      cfg,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] bus_byte;
        logic              frame_start;
        logic              frame_end;
        logic              last;
    } frame_byte_t;

    // segment codes for digits 0..F, digit 0 in the low byte
    localparam logic [16*BYTE_W-1:0] SEG_ROM = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    frame_byte_t       exp_bytes[$];
    logic [BRT_W-1:0]  brightness_q;
    logic              enable_q;
    frame_byte_t       got;
    frame_byte_t       want;

    initial fail_count = 0;

    function automatic void push_byte(logic [BYTE_W-1:0] b, logic fs, logic fe, logic lst);
        frame_byte_t fb;
        fb.bus_byte    = b;
        fb.frame_start = fs;
        fb.frame_end   = fe;
        fb.last        = lst;
        exp_bytes.push_back(fb);
    endfunction

    function automatic void predict_frame_bytes(
        logic              op,
        logic [NUM_W-1:0]  num,
        logic [BASE_W-1:0] base_in,
        logic [DOT_W-1:0]  dots,
        logic              lz,
        logic [CNT_W-1:0]  cnt_in,
        logic [POS_W-1:0]  pos
    );
        logic [BYTE_W-1:0] cells [NUM_DIGITS_DEF];
        int unsigned       radix;
        int unsigned       count;
        int unsigned       value;
        int unsigned       d;
        int unsigned       j;
        int unsigned       i;
        logic [POS_W-1:0]  addr;
        for (i = 0; i < NUM_DIGITS_DEF; i++)
            cells[i] = '0;
        if (op == OP_BLANK)
        begin
            count = NUM_DIGITS_DEF;
            addr  = '0;
        end
        else
        begin
            radix = 32'(base_in);
            if (radix < 32'(BASE_MIN)) radix = 32'(BASE_MIN);
            if (radix > 32'(BASE_MAX)) radix = 32'(BASE_MAX);
            count = 32'(cnt_in);
            if (count < 1) count = 1;
            if (count > NUM_DIGITS_DEF) count = NUM_DIGITS_DEF;
            addr  = pos;
            value = 32'(num);
            if (value == 0 && !lz)
                cells[count-1] = SEG_ROM[0 +: BYTE_W];
            else
            begin
                // least significant digit fills the last cell; excess high digits fall off
                j = count;
                while (j > 0)
                begin
                    d = value % radix;
                    j--;
                    if (d == 0 && value == 0 && !lz)
                        cells[j] = '0;
                    else
                        cells[j] = SEG_ROM[d*BYTE_W +: BYTE_W];
                    value = value / radix;
                end
            end
            // point bits land on blank cells too
            for (i = 0; i < NUM_DIGITS_DEF; i++)
                if (dots[DOT_W-1-i])
                    cells[i][BYTE_W-1] = 1'b1;
        end
        push_byte(CMD_DATA_MODE, 1'b1, 1'b1, 1'b0);
        push_byte(CMD_ADDRESS | ({6'd0, addr} & ADDR_MASK), 1'b1, 1'b0, 1'b0);
        for (i = 0; i < count; i++)
            push_byte(cells[i], 1'b0, (i + 1 == count), 1'b0);
        push_byte(CMD_CONTROL | ({4'd0, enable_q, brightness_q} & CTRL_MASK),
                  1'b1, 1'b1, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [BYTE_W-1:0] exp_v,
                                        logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_q = 3'd7;
            enable_q     = 1'b0;
            exp_bytes.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_BRIGHTNESS: brightness_q = cfg.data[BRT_W-1:0];
                    REG_ENABLE:     enable_q     = cfg.data[0];
                    default:        ;
                endcase
            end
            if (frame.valid && frame.ready)
            begin
                got.bus_byte    = frame.bus_byte;
                got.frame_start = frame.frame_start;
                got.frame_end   = frame.frame_end;
                got.last        = frame.last;
                if (exp_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual %0h", $time,
                             got.bus_byte);
                    fail_count++;
                end
                else
                begin
                    want = exp_bytes.pop_front();
                    check_field("bus_byte", want.bus_byte, got.bus_byte);
                    check_field("frame_start", {7'd0, want.frame_start},
                                {7'd0, got.frame_start});
                    check_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
                    check_field("last", {7'd0, want.last}, {7'd0, got.last});
                end
            end
            if (req.valid && req.ready)
                predict_frame_bytes(req.opcode, req.number, req.base, req.dot_mask,
                                    req.show_leading_zeros, req.digit_count,
                                    req.start_position);
            pending = exp_bytes.size();
        end
    end

endmodule

### sim/tb_top.sv
// Top of the frame builder testbench: clock, reset, request and configuration stimulus,
// frame-side back-pressure and the verdict. Depends on ssnfb_pkg, the ssnfb_*_if
// interfaces, seven_segment_number_frame_builder and ssnfb_frame_checker.
`timescale 1ns / 1ps

module tb_top;
    import ssnfb_pkg::*;

    localparam int  LONG_STALL = 300;          // receiver hold-off, in cycles
    localparam time LIMIT_NS   = 5_000_000;    // generous bound on the whole run

    typedef struct {
        logic              opcode;
        logic [NUM_W-1:0]  number;
        logic [BASE_W-1:0] base;
        logic [DOT_W-1:0]  dot_mask;
        logic              show_leading_zeros;
        logic [CNT_W-1:0]  digit_count;
        logic [POS_W-1:0]  start_position;
    } display_req_t;

    logic clk;
    logic rst_n;

    int   fail_count;
    int   pending;

    // pacing, changed by the stimulus just after a rising edge
    int   src_idle_pct;
    int   snk_idle_pct;
    logic stall_tgl;
    logic stall_seen;
    int   stall_left;

    ssnfb_req_if   req_if();
    ssnfb_frame_if frame_if();
    ssnfb_cfg_if   cfg_if();

    seven_segment_number_frame_builder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .frame (frame_if),
        .cfg   (cfg_if)
    );

    ssnfb_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .frame      (frame_if),
        .cfg        (cfg_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run bound: a hang anywhere ends here
    initial
    begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // frame receiver: random idling, plus one long hold-off per toggle of stall_tgl
    initial
    begin
        frame_if.ready = 1'b0;
        stall_seen     = 1'b0;
        stall_left     = 0;
        forever
        begin
            @(negedge clk);
            if (stall_tgl != stall_seen)
            begin
                stall_seen = stall_tgl;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                frame_if.ready = 1'b0;
                stall_left--;
            end
            else
                frame_if.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic display_req_t make_req(logic op, logic [NUM_W-1:0] num,
                                              logic [BASE_W-1:0] b, logic [DOT_W-1:0] dots,
                                              logic lz, logic [CNT_W-1:0] cnt,
                                              logic [POS_W-1:0] pos);
        display_req_t r;
        r.opcode             = op;
        r.number             = num;
        r.base               = b;
        r.dot_mask           = dots;
        r.show_leading_zeros = lz;
        r.digit_count        = cnt;
        r.start_position     = pos;
        return r;
    endfunction

    // mostly sane requests; a fifth carry out-of-range base or count
    function automatic display_req_t random_req();
        display_req_t r;
        int           sel;
        r.opcode = ($urandom_range(9) == 0) ? OP_BLANK : OP_SHOW;
        sel = $urandom_range(7);
        case (sel)
            0:       r.number = '0;
            1:       r.number = NUM_W'($urandom_range(0, 15));
            2:       r.number = NUM_W'($urandom_range(0, 255));
            default: r.number = NUM_W'($urandom_range(0, 65535));
        endcase
        sel = $urandom_range(9);
        if (sel < 3)      r.base = 5'd10;
        else if (sel < 5) r.base = 5'd16;
        else if (sel < 8) r.base = BASE_W'($urandom_range(2, 16));
        else              r.base = BASE_W'($urandom_range(0, 31));
        r.dot_mask           = DOT_W'($urandom_range(0, 255));
        r.show_leading_zeros = 1'($urandom_range(1));
        r.digit_count        = CNT_W'(($urandom_range(9) < 8) ? $urandom_range(1, 4)
                                                              : $urandom_range(0, 7));
        r.start_position     = POS_W'($urandom_range(0, 3));
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken;
    // valid stays high into the next item unless a gap is drawn
    task automatic drive_req(display_req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid              = 1'b1;
        req_if.opcode             = r.opcode;
        req_if.number             = r.number;
        req_if.base               = r.base;
        req_if.dot_mask           = r.dot_mask;
        req_if.show_leading_zeros = r.show_leading_zeros;
        req_if.digit_count        = r.digit_count;
        req_if.start_position     = r.start_position;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic drive_random(int n);
        repeat (n) drive_req(random_req());
    endtask

    // stop offering and let every outstanding byte drain
    task automatic settle();
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // brightness then display enable, back to back; block must be idle
    task automatic write_config(logic [CFG_DATA_W-1:0] bright, logic [CFG_DATA_W-1:0] en);
        cfg_if.valid = 1'b1;
        cfg_if.index = REG_BRIGHTNESS;
        cfg_if.data  = bright;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.index = REG_ENABLE;
        cfg_if.data  = en;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_pace(int src_pct, int snk_pct);
        @(posedge clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        src_idle_pct = 15;
        snk_idle_pct = 71;
        stall_tgl    = 1'b0;
        req_if.valid              = 1'b0;
        req_if.opcode             = OP_SHOW;
        req_if.number             = '0;
        req_if.base               = 5'd10;
        req_if.dot_mask           = '0;
        req_if.show_leading_zeros = 1'b0;
        req_if.digit_count        = 3'd4;
        req_if.start_position     = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_BRIGHTNESS;
        cfg_if.data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed items under reset configuration (brightness 7, display off)
        // zero: lone "0" when blanking, all zeros when shown
        drive_req(make_req(OP_SHOW, 16'd0, 5'd10, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'd0, 5'd10, 8'h00, 1'b1, 3'd4, 2'd0));
        // full scale in several bases, high digits dropped in binary, decimal and ternary
        drive_req(make_req(OP_SHOW, 16'hFFFF, 5'd16, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'hFFFF, 5'd2, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'hFFFF, 5'd10, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'hFFFF, 5'd3, 8'h00, 1'b0, 3'd4, 2'd0));
        // every letter (all points set on the first), then 1234 with alternate points
        drive_req(make_req(OP_SHOW, 16'hABCD, 5'd16, 8'hFF, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'h0EF0, 5'd16, 8'h00, 1'b1, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'd1234, 5'd10, 8'hAA, 1'b0, 3'd4, 2'd0));
        // points on blanked leading cells
        drive_req(make_req(OP_SHOW, 16'd7, 5'd10, 8'hF0, 1'b0, 3'd4, 2'd0));
        // base below 2 and above 16 are clamped
        drive_req(make_req(OP_SHOW, 16'd5, 5'd0, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'd5, 5'd1, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'h1F3A, 5'd17, 8'h00, 1'b0, 3'd4, 2'd0));
        drive_req(make_req(OP_SHOW, 16'h1F3A, 5'd31, 8'h00, 1'b0, 3'd4, 2'd0));
        // digit count 0 becomes 1, above four becomes four
        drive_req(make_req(OP_SHOW, 16'd42, 5'd10, 8'h80, 1'b0, 3'd0, 2'd2));
        drive_req(make_req(OP_SHOW, 16'd42, 5'd10, 8'h00, 1'b1, 3'd5, 2'd1));
        drive_req(make_req(OP_SHOW, 16'd42, 5'd10, 8'h00, 1'b0, 3'd7, 2'd0));
        // short frames at start positions 3, 1 and 2; low mask bits beyond the cells
        drive_req(make_req(OP_SHOW, 16'd9, 5'd10, 8'h00, 1'b0, 3'd1, 2'd3));
        drive_req(make_req(OP_SHOW, 16'hFF, 5'd16, 8'h0F, 1'b1, 3'd2, 2'd1));
        drive_req(make_req(OP_SHOW, 16'd305, 5'd10, 8'h40, 1'b0, 3'd3, 2'd2));
        // blank ignores every other field
        drive_req(make_req(OP_BLANK, 16'd0, 5'd0, 8'h00, 1'b0, 3'd0, 2'd0));
        drive_req(make_req(OP_BLANK, 16'hFFFF, 5'd31, 8'hFF, 1'b1, 3'd7, 2'd3));
        settle();

        // lowest brightness, display on; sender mostly busy, receiver mostly idle
        write_config(3'd0, 3'd1);
        drive_random(130);
        settle();

        // full brightness; enable written with spare upper bits set
        write_config(3'd7, 3'd7);
        set_pace(71, 15);
        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        stall_tgl = ~stall_tgl;
        @(negedge clk);
        drive_random(130);
        settle();

        // mid brightness, display off via an even write value; no idling at all
        write_config(3'd3, 3'd6);
        set_pace(0, 0);
        drive_random(140);
        settle();

        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ssnfb_pkg.sv
hw/rtl/ssnfb_req_if.sv
hw/rtl/ssnfb_frame_if.sv
hw/rtl/ssnfb_cfg_if.sv
hw/rtl/ssnfb_div.sv
hw/rtl/seven_segment_number_frame_builder.sv
hw/rtl/ssnfb_checker.sv
sim/ssnfb_frame_checker.sv
sim/tb_top.sv
